FILE: rtl/core/mild_pkg.sv
// Package for the multichannel IIR low-pass decimator.
// Holds widths, coefficient tables and shared control types. No dependencies.
`default_nettype none
package mild_pkg;
  localparam int NumChannelsDefault = 8;
  localparam int SampleW = 16;
  localparam int HistW   = 32;
  localparam int AccW    = 64;
  localparam int UvW     = 24;
  localparam int IdxW    = 16;
  localparam int CodeW   = 3;
  localparam int Taps    = 4;
  localparam logic [15:0] BlockLenReset = 16'd25600;
  localparam logic [16:0] BaseRate = 17'd25600;
  localparam int UvLimit = 6000000;
  localparam logic [16:0] UvScale = 17'd78125;

  localparam logic [0:0] RegRateCodes   = 1'b0;
  localparam logic [0:0] RegBlockLength = 1'b1;

  typedef logic signed [31:0] coef_t;

  // Tap schedule: step 0 takes the new sample, steps 1..4 the input history,
  // steps 5..8 the output history.
  function automatic coef_t coef_of(input logic [2:0] code, input logic [3:0] step);
    coef_t b0, b1, b2, a1, a2, a3, a4;
    begin
      b0 = 0; b1 = 0; b2 = 0; a1 = 0; a2 = 0; a3 = 0; a4 = 0;
      case (code)
        3'd1: begin
          b0 = 11601125; b1 = 46404500; b2 = 69606750;
          a1 = -229685876; a2 = 192822215; a3 = -54738405; a4 = 8784610;
        end
        3'd2: begin
          b0 = 1194440; b1 = 4777760; b2 = 7166639;
          a1 = -646197945; a2 = 637411973; a3 = -292930757; a4 = 52392312;
        end
        3'd3: begin
          b0 = 250584; b1 = 1002337; b2 = 1503505;
          a1 = -799090566; a2 = 918669219; a3 = -479454340; a4 = 95449577;
        end
        3'd4: begin
          b0 = 6555; b1 = 26220; b2 = 39330;
          a1 = -970488851; a2 = 1320250323; a3 = -800708430; a4 = 182616383;
        end
        default: begin
        end
      endcase
      case (step)
        4'd0: coef_of = b0;
        4'd1: coef_of = b1;
        4'd2: coef_of = b2;
        4'd3: coef_of = b1;
        4'd4: coef_of = b0;
        4'd5: coef_of = a1;
        4'd6: coef_of = a2;
        4'd7: coef_of = a3;
        4'd8: coef_of = a4;
        default: coef_of = 0;
      endcase
    end
  endfunction

  typedef struct packed {
    logic       load;      // latch item, clear accumulator
    logic       mac;       // one tap product into the accumulator
    logic [3:0] step;
    logic       finish;    // form y and update history
    logic       scale;     // y * scale
    logic       commit;    // form result, update counters
  } mild_cmd_t;

  typedef struct packed {
    logic filt;    // channel runs the filter
    logic skip;    // channel out of range
  } mild_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/mild_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on nothing.
`default_nettype none
interface mild_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mild_ctrl.sv
// Sequencer for the decimator: load, scale, nine MAC steps, finish, commit.
// Depends on mild_pkg.
`default_nettype none
module mild_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                res_pending,
  input  wire mild_pkg::mild_sts_t sts,
  output mild_pkg::mild_cmd_t      cmd
);
  import mild_pkg::*;
  typedef enum logic [2:0] {IDLE, MAC, FIN, SCL, CMT} state_t;
  state_t state;
  logic [3:0] step;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.step = step;
    cmd.mac = (state == MAC);
    cmd.finish = (state == FIN);
    cmd.scale = (state == SCL);
    cmd.commit = (state == CMT) && !res_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step <= '0;
    end else begin
      case (state)
        IDLE: if (in_valid && in_ready) begin
          step <= '0;
          state <= SCL;
        end
        SCL: if (sts.skip) state <= IDLE;
          else if (sts.filt) state <= MAC;
          else state <= CMT;
        MAC: begin
          step <= step + 4'd1;
          if (step == 4'd8) state <= FIN;
        end
        FIN: state <= CMT;
        // A result still waiting in the output register holds the commit.
        CMT: if (!res_pending) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  // Scale reuses SCL before MAC for passthrough; filtered items rescale in FIN.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !in_ready) else $error("accept while busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == MAC) |-> (step <= 4'd8)) else $error("step overrun");
  a_fin_after_mac: assert property (@(posedge clk) disable iff (rst)
    (state == FIN) |-> ($past(state) == MAC)) else $error("bad finish");
endmodule
`default_nettype wire

FILE: rtl/core/mild_dp.sv
// Datapath: history, shared MAC, scaling, decimation and framing state.
// Depends on mild_pkg.
`default_nettype none
module mild_dp #(
  parameter int NUM_CHANNELS = mild_pkg::NumChannelsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mild_pkg::mild_cmd_t  cmd,
  output mild_pkg::mild_sts_t       sts,
  input  wire logic signed [15:0]   in_sample,
  input  wire logic [2:0]           in_channel,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_idx,
  input  wire logic [23:0]          cfg_data,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic                      o_stored,
  output logic signed [23:0]        o_value_uv,
  output logic [2:0]                o_channel,
  output logic [15:0]               o_store_index,
  output logic                      o_buffer_select,
  output logic                      o_block_done
);
  import mild_pkg::*;
  localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [23:0] rate_codes;
  logic [15:0] block_length;
  logic [15:0] div_tab [5];
  logic signed [15:0] xh [NUM_CHANNELS][Taps];
  logic signed [31:0] yh [NUM_CHANNELS][Taps];
  logic [15:0] dcnt [NUM_CHANNELS];
  logic [15:0] frame_index;
  logic active_buffer;

  logic signed [15:0] x_r;
  logic [2:0] ch_r, code_r;
  logic signed [63:0] acc;
  logic signed [31:0] y_r;
  logic signed [48:0] prod_r;
  logic signed [63:0] prod;
  logic signed [31:0] opnd;
  logic [ChW-1:0] ci;
  logic [2:0] code_c;
  logic signed [63:0] yfull;
  logic signed [31:0] y_sat;
  logic signed [49:0] uvr;
  logic signed [26:0] uv_sh;
  logic signed [23:0] uv_sat;
  logic [16:0] cnt1;
  logic kept, wrap;
  logic [16:0] fnext;

  assign ci = ch_r[ChW-1:0];
  always_comb begin
    code_c = rate_codes[3*in_channel +: 3];
    if (code_c > 3'd4) code_c = 3'd0;
  end
  assign sts.skip = ({29'd0, ch_r} >= NUM_CHANNELS);
  assign sts.filt = (code_r != 3'd0);

  always_comb begin
    case (cmd.step)
      4'd0: opnd = 32'(x_r);
      4'd1, 4'd2, 4'd3, 4'd4: opnd = 32'(xh[ci][cmd.step[1:0] - 2'd1]);
      default: opnd = yh[ci][cmd.step[1:0] - 2'd1];
    endcase
    prod = 64'(coef_of(code_r, cmd.step)) * 64'(opnd);
    yfull = (acc + 64'sd134217728) >>> 28;
    if (yfull > 64'sd2147483647) y_sat = 32'h7fffffff;
    else if (yfull < -64'sd2147483648) y_sat = 32'h80000000;
    else y_sat = yfull[31:0];
    uvr = 50'(prod_r) + 50'sd4194304;
    uv_sh = 27'(uvr >>> 23);
    if (uv_sh > 27'sd6000000) uv_sat = 24'sd6000000;
    else if (uv_sh < -27'sd6000000) uv_sat = -24'sd6000000;
    else uv_sat = uv_sh[23:0];
    cnt1 = {1'b0, dcnt[ci]} + 17'd1;
    kept = cnt1 >= {1'b0, div_tab[code_r]};
    fnext = {1'b0, frame_index} + 17'd1;
    wrap = (ch_r == 3'(NUM_CHANNELS - 1)) && (fnext >= {1'b0, block_length});
  end

  // Divisors are computed once per block_length write. The base rate for code k is
  // 100 times a power of two, so the length is shifted first and then divided by
  // 100 through a reciprocal multiply, exact for shifted lengths of up to 12 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_codes <= '0;
      block_length <= BlockLenReset;
      div_tab[0] <= 16'd1; div_tab[1] <= 16'd2; div_tab[2] <= 16'd4;
      div_tab[3] <= 16'd8; div_tab[4] <= 16'd16;
    end else if (cfg_we) begin
      if (cfg_idx == RegRateCodes) rate_codes <= cfg_data;
      else begin
        block_length <= cfg_data[15:0];
        for (int k = 0; k < 5; k++)
          div_tab[k] <= 16'(((32'(cfg_data[15:0]) >> (8 - k)) * 32'd5243) >> 19);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_sample;
      ch_r <= in_channel;
      code_r <= code_c;
      acc <= '0;
      y_r <= 32'(in_sample) <<< 14;
    end
    if (cmd.mac) acc <= (cmd.step <= 4'd4) ? acc + (prod <<< 14) : acc - prod;
    if (cmd.finish) y_r <= y_sat;
    prod_r <= 49'(cmd.finish ? y_sat : y_r) * 49'(signed'({1'b0, UvScale}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        dcnt[c] <= '0;
        for (int t = 0; t < Taps; t++) begin
          xh[c][t] <= '0;
          yh[c][t] <= '0;
        end
      end
      frame_index <= '0;
      active_buffer <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.finish) begin
        for (int t = Taps - 1; t > 0; t--) begin
          xh[ci][t] <= xh[ci][t-1];
          yh[ci][t] <= yh[ci][t-1];
        end
        xh[ci][0] <= x_r;
        yh[ci][0] <= y_sat;
      end
      if (cmd.commit) begin
        dcnt[ci] <= kept ? 16'd0 : cnt1[15:0];
        if (ch_r == 3'(NUM_CHANNELS - 1)) frame_index <= wrap ? 16'd0 : fnext[15:0];
        if (wrap) begin
          for (int c = 0; c < NUM_CHANNELS; c++) dcnt[c] <= '0;
          active_buffer <= ~active_buffer;
        end
        res_valid <= kept || wrap;
        o_stored <= kept;
        o_value_uv <= kept ? uv_sat : 24'sd0;
        o_channel <= ch_r;
        o_store_index <= kept ? (frame_index >> code_r) : 16'd0;
        o_buffer_select <= active_buffer;
        o_block_done <= wrap;
      end
    end
  end

  a_commit_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !res_valid) |=> (res_valid == ($past(kept) || $past(wrap))))
    else $error("result valid mismatch");
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit && wrap) |-> (frame_index == 16'd0)) else $error("wrap");
  a_skip_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.mac) |-> !sts.skip) else $error("mac on skipped item");
endmodule
`default_nettype wire

FILE: rtl/core/multichannel_iir_lowpass_decimator.sv
// Top level of the multichannel IIR low-pass decimator.
// Depends on mild_pkg, mild_if, mild_ctrl and mild_dp.
// Usage:
//   in  : valid/ready channel of items {sample, channel}, interleaved channels.
//   out : valid/ready channel of results {stored, value_uv, out_channel,
//         store_index, buffer_select, block_done}; zero or one per item.
//   cfg : write channel {index, data}; index 0 is rate_codes, 1 block_length.
//         Write only while idle; always ready.
// An item of a passthrough channel passes through scale and commit before its
// result; a filtered item passes through scale, the nine taps through one shared
// multiplier, finish and commit, in that order.
// A new item is taken once the previous one has committed or was skipped. A
// result waiting in the output register holds the next item at its commit, so a
// long receiver stall fills the block and then holds the input.
// Reset clears history, counters, frame index and buffer bit, restores
// block_length to 25600 and rate codes to passthrough.
`default_nettype none
module multichannel_iir_lowpass_decimator #(
  parameter int NUM_CHANNELS = mild_pkg::NumChannelsDefault
) (
  input wire logic clk,
  input wire logic rst,
  mild_if.sink     in,
  mild_if.source   out,
  mild_if.sink     cfg
);
  import mild_pkg::*;
  mild_cmd_t cmd;
  mild_sts_t sts;
  logic res_valid;

  assign cfg.ready = 1'b1;
  assign out.valid = res_valid;

  mild_ctrl u_ctrl (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready),
    .res_pending(res_valid), .sts, .cmd
  );

  mild_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .in_sample(in.data.sample), .in_channel(in.data.channel),
    .cfg_we(cfg.valid), .cfg_idx(cfg.data.index[0]), .cfg_data(cfg.data.data),
    .res_valid, .res_ready(out.ready),
    .o_stored(out.data.stored), .o_value_uv(out.data.value_uv),
    .o_channel(out.data.out_channel), .o_store_index(out.data.store_index),
    .o_buffer_select(out.data.buffer_select), .o_block_done(out.data.block_done)
  );
endmodule
`default_nettype wire
